>>> sv/bdq_pkg.sv
// Shared constants, codes and handshake structs of the byte deque.
// Depends on nothing; every other file of the block imports it.
package bdq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OP_W    = 3;
    localparam int DATA_W  = 8;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SORT       = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic              capture;
        logic              push;
        logic              pop;
        logic              sort_load;
        logic              sort_first;
        logic              sort_step;
        logic              sort_last;
        logic              finish;
        logic              pop_result;
        logic [STAT_W-1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             full;
        logic             empty;
        logic             short_q;
        logic             step_more;
        logic             changed;
        logic [CNT_W-1:0] count;
    } t_dp_sts;

    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

>>> sv/bdq_ctrl.sv
// Controller state machine of the byte deque: sequences push, pop and sort.
// Depends on bdq_pkg; drives the command struct of bdq_datapath.
module bdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  bdq_pkg::t_dp_sts i_sts,
    output bdq_pkg::t_dp_cmd o_cmd
);
    import bdq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_POPW   = 3'd2;
    localparam logic [2:0] S_SLOAD  = 3'd3;
    localparam logic [2:0] S_SFIRST = 3'd4;
    localparam logic [2:0] S_SSTEP  = 3'd5;
    localparam logic [2:0] S_SLAST  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = STAT_OK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        o_cmd.finish = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.status = STAT_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (i_sts.empty) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = STAT_EMPTY;
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.pop = 1'b1;
                            n_state = S_POPW;
                        end
                    end
                    OP_SORT: begin
                        if (i_sts.short_q) begin
                            o_cmd.finish = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.sort_load = 1'b1;
                            n_state = S_SFIRST;
                        end
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_POPW: begin
                o_cmd.finish     = 1'b1;
                o_cmd.pop_result = 1'b1;
                n_state = S_IDLE;
            end
            S_SLOAD: begin
                o_cmd.sort_load = 1'b1;
                n_state = S_SFIRST;
            end
            S_SFIRST: begin
                o_cmd.sort_first = 1'b1;
                n_state = S_SSTEP;
            end
            S_SSTEP: begin
                o_cmd.sort_step = 1'b1;
                if (!i_sts.step_more) begin
                    n_state = S_SLAST;
                end
            end
            S_SLAST: begin
                o_cmd.sort_last = 1'b1;
                if (i_sts.changed) begin
                    n_state = S_SLOAD;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/bdq_datapath.sv
// Datapath of the byte deque: ring memory, head and count, sort carry, result registers.
// Depends on bdq_pkg; commanded by bdq_ctrl.
module bdq_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bdq_pkg::OP_W-1:0]      i_op,
    input  logic [bdq_pkg::DATA_W-1:0]    i_push_value,
    input  bdq_pkg::t_dp_cmd              i_cmd,
    output bdq_pkg::t_dp_sts              o_sts,
    output logic                          o_done,
    output logic [bdq_pkg::DATA_W-1:0]    o_pop_value,
    output logic [bdq_pkg::STAT_W-1:0]    o_status,
    output logic [bdq_pkg::TOTAL_W-1:0]   o_entry_total
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_value;
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  n_head;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_j;
    logic [DATA_W-1:0] r_carry;
    logic              r_changed;
    logic              r_done;
    logic [DATA_W-1:0] r_pop_value;
    logic [STAT_W-1:0] r_status;

    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [IDX_W-1:0]  w_raddr;
    logic              w_swap;
    logic [CNT_W-1:0]  w_last;
    logic [CNT_W:0]    w_jnext;

    assign w_swap  = (r_carry > r_rdata);
    assign w_last  = r_count - CNT_W'(1);
    assign w_jnext = (CNT_W+1)'(r_j) + (CNT_W+1)'(1);

    assign o_sts.op        = r_op;
    assign o_sts.full      = (r_count == CNT_W'(DEPTH));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.short_q   = (r_count < CNT_W'(2));
    assign o_sts.step_more = (w_jnext < (CNT_W+1)'(r_count));
    assign o_sts.changed   = r_changed;
    assign o_sts.count     = r_count;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_value;
        w_raddr = r_head;
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.push) begin
            w_we    = 1'b1;
            n_count = r_count + CNT_W'(1);
            if (r_op == OP_PUSH_FRONT) begin
                w_waddr = ring_pos(r_head, CNT_W'(DEPTH - 1));
                n_head  = w_waddr;
            end else begin
                w_waddr = ring_pos(r_head, r_count);
            end
        end
        if (i_cmd.pop) begin
            n_count = w_last;
            if (r_op == OP_POP_FRONT) begin
                w_raddr = r_head;
                n_head  = ring_pos(r_head, CNT_W'(1));
            end else begin
                w_raddr = ring_pos(r_head, w_last);
            end
        end
        if (i_cmd.sort_first) begin
            w_raddr = ring_pos(r_head, CNT_W'(1));
        end
        if (i_cmd.sort_step) begin
            w_we    = 1'b1;
            w_waddr = ring_pos(r_head, r_j - CNT_W'(1));
            w_wdata = w_swap ? r_rdata : r_carry;
            w_raddr = ring_pos(r_head, w_jnext[CNT_W-1:0]);
        end
        if (i_cmd.sort_last) begin
            w_we    = 1'b1;
            w_waddr = ring_pos(r_head, w_last);
            w_wdata = r_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_value <= i_push_value;
        end
        if (i_cmd.sort_first) begin
            r_carry <= r_rdata;
            r_j     <= CNT_W'(1);
        end
        if (i_cmd.sort_step) begin
            r_carry <= w_swap ? r_carry : r_rdata;
            r_j     <= w_jnext[CNT_W-1:0];
        end
        if (i_cmd.sort_load) begin
            r_changed <= 1'b0;
        end else if (i_cmd.sort_step && w_swap) begin
            r_changed <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_status    <= i_cmd.status;
            r_pop_value <= i_cmd.pop_result ? r_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= i_cmd.finish;
        end
    end

    assign o_done        = r_done;
    assign o_pop_value   = r_pop_value;
    assign o_status      = r_status;
    assign o_entry_total = TOTAL_W'(r_count);

endmodule

>>> sv/byte_deque_with_sort.sv
// Top level of the byte deque with in-place sort: joins controller and datapath.
// Depends on bdq_pkg, bdq_ctrl and bdq_datapath.
//
// An item is taken when start is high and busy is low, and its result shows on
// the o_ ports for one cycle with o_done high; the receiver cannot stall, so
// capture it then. A push, a push on a full queue, a pop on an empty queue, an
// unused code and a sort of fewer than two entries finish in the execute state,
// after which the result is registered onto the o_ ports; a pop finishes in a
// wait state after it, because the ring is a memory with a registered read port.
// A sort of N entries runs bubble passes, one entry per cycle through the single
// write port of the ring, and repeats passes until one makes no swap. busy falls
// in the cycle the result appears, and the next item may be accepted in that cycle.
module byte_deque_with_sort (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bdq_pkg::OP_W-1:0]      i_op,
    input  logic [bdq_pkg::DATA_W-1:0]    i_push_value,
    output logic                          o_done,
    output logic [bdq_pkg::DATA_W-1:0]    o_pop_value,
    output logic [bdq_pkg::STAT_W-1:0]    o_status,
    output logic [bdq_pkg::TOTAL_W-1:0]   o_entry_total
);
    import bdq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    bdq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_op),
        .i_push_value  (i_push_value),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_done        (o_done),
        .o_pop_value   (o_pop_value),
        .o_status      (o_status),
        .o_entry_total (o_entry_total)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.count <= CNT_W'(DEPTH))
        else $error("entry count exceeds the ring depth");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == STAT_FULL) |-> w_sts.full)
        else $error("full status reported while the ring has room");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == STAT_EMPTY) |-> (w_sts.empty && o_pop_value == '0))
        else $error("empty status reported with entries held or a nonzero value");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

endmodule

>>> bench/byte_deque_with_sort_tb.sv
// Self-checking testbench of byte_deque_with_sort: directed and random deque operations.
// Depends on bdq_pkg and byte_deque_with_sort; an internal deque model predicts every result.
module byte_deque_with_sort_tb;
    import bdq_pkg::*;

    localparam int N_RANDOM     = 420;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0]  pop_value;
        logic [STAT_W-1:0]  status;
        logic [TOTAL_W-1:0] total;
    } t_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_op = '0;
    logic [DATA_W-1:0]   i_push_value = '0;
    logic                o_done;
    logic [DATA_W-1:0]   o_pop_value;
    logic [STAT_W-1:0]   o_status;
    logic [TOTAL_W-1:0]  o_entry_total;

    t_item               op_queue[$];
    t_result             result_queue[$];
    t_result             oldest;
    logic [DATA_W-1:0]   ring_model[DEPTH];
    int                  head_model = 0;
    int                  count_model = 0;
    int                  item_total = 1;
    int                  accepted = 0;
    int                  errors = 0;
    int                  cycles = 0;

    byte_deque_with_sort i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_push_value  (i_push_value),
        .o_done        (o_done),
        .o_pop_value   (o_pop_value),
        .o_status      (o_status),
        .o_entry_total (o_entry_total)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_result deque_step(input t_item it);
        t_result           r;
        int                p;
        int                q;
        logic [DATA_W-1:0] t;
        bit                swapped;
        r.pop_value = '0;
        r.status    = STAT_OK;
        case (it.op)
            OP_PUSH_FRONT: begin
                if (count_model >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    head_model = (head_model + DEPTH - 1) % DEPTH;
                    ring_model[head_model] = it.value;
                    count_model++;
                end
            end
            OP_PUSH_BACK: begin
                if (count_model >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    ring_model[(head_model + count_model) % DEPTH] = it.value;
                    count_model++;
                end
            end
            OP_POP_FRONT: begin
                if (count_model == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.pop_value = ring_model[head_model];
                    head_model = (head_model + 1) % DEPTH;
                    count_model--;
                end
            end
            OP_POP_BACK: begin
                if (count_model == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.pop_value = ring_model[(head_model + count_model - 1) % DEPTH];
                    count_model--;
                end
            end
            OP_SORT: begin
                swapped = 1'b1;
                while (swapped) begin
                    swapped = 1'b0;
                    for (int k = 0; k + 1 < count_model; k++) begin
                        p = (head_model + k) % DEPTH;
                        q = (head_model + k + 1) % DEPTH;
                        if (ring_model[p] > ring_model[q]) begin
                            t = ring_model[p];
                            ring_model[p] = ring_model[q];
                            ring_model[q] = t;
                            swapped = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.total = TOTAL_W'(count_model);
        return r;
    endfunction

    function automatic int idle_percent(input int n);
        case ((n * 4) / item_total)
            1:       return 46;
            3:       return 36;
            default: return 0;
        endcase
    endfunction

    task automatic add_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        t_item it;
        it.op    = op;
        it.value = value;
        op_queue.push_back(it);
    endtask

    // A held item stays on the ports until busy is low at an edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                result_queue.push_back(deque_step(op_queue.pop_front()));
                accepted++;
            end
            if (!(start && busy)) begin
                if (op_queue.size() != 0 && $urandom_range(99) >= idle_percent(accepted)) begin
                    start        <= 1'b1;
                    i_op         <= op_queue[0].op;
                    i_push_value <= op_queue[0].value;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (result_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: pop_value %0d status %0d total %0d",
                         $time, o_pop_value, o_status, o_entry_total);
            end else begin
                oldest = result_queue.pop_front();
                if (o_pop_value !== oldest.pop_value) begin
                    errors++;
                    $display("%0t: pop_value expected %0d actual %0d",
                             $time, oldest.pop_value, o_pop_value);
                end
                if (o_status !== oldest.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest.status, o_status);
                end
                if (o_entry_total !== oldest.total) begin
                    errors++;
                    $display("%0t: entry_total expected %0d actual %0d",
                             $time, oldest.total, o_entry_total);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int n_rand;
        int mode;
        int burst;
        int r;
        logic [OP_W-1:0] op;

        add_item(OP_POP_FRONT, 8'hA5);
        add_item(OP_POP_BACK, 8'h5A);
        add_item(OP_SORT, 8'hFF);
        add_item(OP_UNUSED_LO, 8'h00);
        add_item(OP_UNUSED_MID, 8'hFF);
        add_item(OP_PUSH_FRONT, 8'hFF);
        add_item(OP_SORT, 8'h00);
        add_item(OP_UNUSED_HI, 8'h3C);
        add_item(OP_POP_BACK, 8'h00);
        // Fill to capacity from both ends with a scrambled set that spans 0 to 255.
        for (int k = 0; k < DEPTH; k++) begin
            add_item(k % 2 ? OP_PUSH_BACK : OP_PUSH_FRONT, DATA_W'(((k * 11) % 16) * 17));
        end
        add_item(OP_PUSH_FRONT, 8'h00);
        add_item(OP_PUSH_BACK, 8'hFF);
        add_item(OP_SORT, 8'h00);
        add_item(OP_POP_FRONT, 8'h00);
        add_item(OP_POP_BACK, 8'h00);

        // Bursts that lean toward filling or draining so that full and empty recur.
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            mode  = $urandom_range(2);
            burst = $urandom_range(24, 4);
            for (int k = 0; k < burst; k++) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
                end else if (r < 10) begin
                    op = OP_SORT;
                end else begin
                    r = $urandom_range(99);
                    if ((mode == 0 && r < 80) || (mode == 1 && r < 30) ||
                        (mode == 2 && r < 50)) begin
                        op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                    end else begin
                        op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
                    end
                end
                add_item(op, DATA_W'($urandom_range(255)));
                n_rand++;
            end
        end
        item_total = op_queue.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() != 0 || start) @(posedge i_clk);
        while (result_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
